// ----- sv/sorted_point_list_macros.svh -----
// Assertion shorthands for the sorted point list. Each expects clk_i and
// rst_ni to be visible where it is used.
`ifndef SORTED_POINT_LIST_MACROS_SVH
`define SORTED_POINT_LIST_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SPL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted point list: invariant violated");

// A condition that must hold in the cycle after the trigger.
`define SPL_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("sorted point list: sequence violated");

`endif

// ----- sv/spl_pkg.sv -----
package spl_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned KindW   = 3;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned PointW  = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  localparam logic [KindW-1:0] KindInsert   = 3'd0;
  localparam logic [KindW-1:0] KindRemove   = 3'd1;
  localparam logic [KindW-1:0] KindRead     = 3'd2;
  localparam logic [KindW-1:0] KindSetCur   = 3'd3;
  localparam logic [KindW-1:0] KindWriteCur = 3'd4;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

  // Operation strobes shared by every cell of the chain.
  typedef struct packed {
    logic do_ins;
    logic do_rem;
    logic do_wr;
  } cell_ctrl_t;

  // Position-dependent selects, one set per cell.
  typedef struct packed {
    logic in_range;   // cell lies below the fill count
    logic at_index;   // cell position equals the index field
    logic at_or_above; // cell position is at or above the index field
    logic at_cur;     // cell position equals the current index
  } cell_sel_t;

endpackage

// ----- sv/spl_cell.sv -----
module spl_cell (
  input  logic                                clk_i,
  input  spl_pkg::cell_ctrl_t                 ctrl_i,
  input  spl_pkg::cell_sel_t                  sel_i,
  input  logic signed [spl_pkg::PointW-1:0]   new_x_i,
  input  logic signed [spl_pkg::PointW-1:0]   new_y_i,
  input  logic signed [spl_pkg::PointW-1:0]   left_x_i,
  input  logic signed [spl_pkg::PointW-1:0]   left_y_i,
  input  logic signed [spl_pkg::PointW-1:0]   right_x_i,
  input  logic signed [spl_pkg::PointW-1:0]   right_y_i,
  input  logic                                pass_i,
  output logic                                pass_o,
  input  logic [2*spl_pkg::PointW-1:0]        rd_i,
  output logic [2*spl_pkg::PointW-1:0]        rd_o,
  output logic signed [spl_pkg::PointW-1:0]   x_o,
  output logic signed [spl_pkg::PointW-1:0]   y_o
);

  logic signed [spl_pkg::PointW-1:0] x_q, x_d;
  logic signed [spl_pkg::PointW-1:0] y_q, y_d;
  logic                              lt;

  // Every live cell to the left, and this one, hold a smaller key.
  assign lt     = sel_i.in_range && (x_q < new_x_i);
  assign pass_o = pass_i && lt;

  // Read data rides along the chain; only the addressed cell adds to it.
  assign rd_o = rd_i | (sel_i.at_index ? {x_q, y_q} : '0);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    priority if (ctrl_i.do_wr && sel_i.at_cur) begin
      x_d = new_x_i;
      y_d = new_y_i;
    end else if (ctrl_i.do_ins) begin
      priority if (pass_o) begin
        x_d = x_q;
        y_d = y_q;
      end else if (pass_i) begin
        x_d = new_x_i;
        y_d = new_y_i;
      end else begin
        x_d = left_x_i;
        y_d = left_y_i;
      end
    end else if (ctrl_i.do_rem && sel_i.at_or_above) begin
      x_d = right_x_i;
      y_d = right_y_i;
    end else begin
      x_d = x_q;
      y_d = y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- sv/sorted_point_list.sv -----
// Sorted point list: every operation is applied in the cycle it is accepted.
// The result appears in the output register in the cycle after acceptance.
// Throughput: one operation per cycle while the result side takes each one;
// the figure is set by the combinational shift and compare across the cell row.
// Reset (asynchronous, active low) empties the list, clears the current mark
// and the result valid flag; the point storage and result payload are not cleared.
module sorted_point_list #(
  parameter int unsigned CAPACITY = spl_pkg::CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [spl_pkg::KindW-1:0]            kind_i,
  input  logic [spl_pkg::IndexW-1:0]           index_i,
  input  logic signed [spl_pkg::PointW-1:0]    point_x_i,
  input  logic signed [spl_pkg::PointW-1:0]    point_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [spl_pkg::PointW-1:0]    read_x_o,
  output logic signed [spl_pkg::PointW-1:0]    read_y_o,
  output logic [spl_pkg::CountW-1:0]           entry_count_o,
  output logic [spl_pkg::StatusW-1:0]          status_o,
  output logic                                 current_valid_o
);

  `include "sorted_point_list_macros.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = spl_pkg::PointW;

  // List state: the fill count and the current mark.
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [spl_pkg::IndexW-1:0]     cur_idx_q, cur_idx_d;
  logic                           cur_en_q, cur_en_d;

  // Output register. The payload carries no reset.
  logic                           out_valid_q;
  logic signed [PW-1:0]           rx_q, ry_q, rx_d, ry_d;
  logic [spl_pkg::CountW-1:0]     ecnt_q;
  logic [spl_pkg::StatusW-1:0]    status_q, status_d;
  logic                           cur_out_q;

  logic                           in_acc;
  logic                           idx_bad;
  logic                           full;
  logic                           cur_bad;
  spl_pkg::cell_ctrl_t            ctrl;

  // The row of cells. Each cell holds one point and sees its two neighbours;
  // the insert position ripples along as a "still smaller" flag and read data
  // is gathered along the same row.
  logic signed [PW-1:0]           cx [CAPACITY];
  logic signed [PW-1:0]           cy [CAPACITY];
  logic [CAPACITY:0]              pass;
  logic [2*PW-1:0]                rd  [CAPACITY+1];
  spl_pkg::cell_sel_t             sel [CAPACITY];

  // A new transaction is taken whenever the output register is free or is
  // being emptied in the same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign full    = 32'(cnt_q) >= 32'(CAPACITY);
  assign idx_bad = 32'(index_i) >= 32'(cnt_q);
  assign cur_bad = !cur_en_q || (32'(cur_idx_q) >= 32'(cnt_q));

  assign ctrl.do_ins = in_acc && (kind_i == spl_pkg::KindInsert) && !full;
  assign ctrl.do_rem = in_acc && (kind_i == spl_pkg::KindRemove) && !idx_bad;
  assign ctrl.do_wr  = in_acc && (kind_i == spl_pkg::KindWriteCur) && !cur_bad;

  assign pass[0] = 1'b1;
  assign rd[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign sel[i].in_range    = 32'(i) < 32'(cnt_q);
    assign sel[i].at_index    = 32'(i) == 32'(index_i);
    assign sel[i].at_or_above = 32'(i) >= 32'(index_i);
    assign sel[i].at_cur      = 32'(i) == 32'(cur_idx_q);

    logic signed [PW-1:0] lx, ly, rxn, ryn;
    // The first cell never shifts from the left: its pass input is always
    // set, so on insert it keeps its point or takes the new one. The last
    // cell has no right neighbour and simply keeps its own point on removal.
    if (i == 0) begin : g_first
      assign lx = cx[i];
      assign ly = cy[i];
    end else begin : g_left
      assign lx = cx[i-1];
      assign ly = cy[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rxn = cx[i];
      assign ryn = cy[i];
    end else begin : g_right
      assign rxn = cx[i+1];
      assign ryn = cy[i+1];
    end

    spl_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .sel_i     (sel[i]),
      .new_x_i   (point_x_i),
      .new_y_i   (point_y_i),
      .left_x_i  (lx),
      .left_y_i  (ly),
      .right_x_i (rxn),
      .right_y_i (ryn),
      .pass_i    (pass[i]),
      .pass_o    (pass[i+1]),
      .rd_i      (rd[i]),
      .rd_o      (rd[i+1]),
      .x_o       (cx[i]),
      .y_o       (cy[i])
    );
  end

  // Next list state and result of the transaction being accepted.
  always_comb begin
    cnt_d     = cnt_q;
    cur_idx_d = cur_idx_q;
    cur_en_d  = cur_en_q;
    rx_d      = '0;
    ry_d      = '0;
    status_d  = spl_pkg::StatusDone;
    unique case (kind_i)
      spl_pkg::KindInsert: begin
        if (full) begin
          status_d = spl_pkg::StatusFull;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      spl_pkg::KindRemove: begin
        if (idx_bad) begin
          status_d = spl_pkg::StatusRange;
        end else begin
          // Removing the marked point drops the mark; otherwise the index
          // is left where it was.
          if (cur_en_q && (cur_idx_q == index_i)) begin
            cur_en_d = 1'b0;
          end
          cnt_d = cnt_q - CntW'(1);
        end
      end
      spl_pkg::KindRead: begin
        if (idx_bad) begin
          status_d = spl_pkg::StatusRange;
        end else begin
          rx_d = rd[CAPACITY][2*PW-1:PW];
          ry_d = rd[CAPACITY][PW-1:0];
        end
      end
      spl_pkg::KindSetCur: begin
        if (idx_bad) begin
          status_d = spl_pkg::StatusRange;
        end else begin
          cur_idx_d = index_i;
          cur_en_d  = 1'b1;
        end
      end
      spl_pkg::KindWriteCur: begin
        if (cur_bad) begin
          status_d = spl_pkg::StatusRange;
        end
      end
      default: begin
        // Unused kinds leave everything alone and report success.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_idx_q   <= '0;
      cur_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q     <= cnt_d;
        cur_idx_q <= cur_idx_d;
        cur_en_q  <= cur_en_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rx_q      <= rx_d;
      ry_q      <= ry_d;
      ecnt_q    <= spl_pkg::CountW'(cnt_d);
      status_q  <= status_d;
      cur_out_q <= cur_en_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_x_o        = rx_q;
  assign read_y_o        = ry_q;
  assign entry_count_o   = ecnt_q;
  assign status_o        = status_q;
  assign current_valid_o = cur_out_q;

  // The fill count never passes the capacity of the cell row.
  `SPL_ASSERT_ALWAYS(a_cnt_cap, 32'(cnt_q) <= 32'(CAPACITY))
  // A successful insert grows the list by exactly one point.
  `SPL_ASSERT_NEXT(a_ins_grow, ctrl.do_ins, cnt_q == $past(cnt_q) + CntW'(1))
  // A successful removal shrinks the list by exactly one point.
  `SPL_ASSERT_NEXT(a_rem_shrink, ctrl.do_rem, cnt_q == $past(cnt_q) - CntW'(1))
  // Every accepted transaction leaves a result waiting in the next cycle.
  `SPL_ASSERT_NEXT(a_acc_result, in_acc, out_valid_q)

endmodule

// ----- bench/spl_checker.sv -----
module spl_checker
  import spl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [KindW-1:0]          kind_i,
  input  logic [IndexW-1:0]         index_i,
  input  logic signed [PointW-1:0]  point_x_i,
  input  logic signed [PointW-1:0]  point_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [PointW-1:0]  read_x_i,
  input  logic signed [PointW-1:0]  read_y_i,
  input  logic [CountW-1:0]         entry_count_i,
  input  logic [StatusW-1:0]        status_i,
  input  logic                      current_valid_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PointW-1:0] read_x;
    logic signed [PointW-1:0] read_y;
    logic [CountW-1:0]        count;
    logic [StatusW-1:0]       status;
    logic                     mark;
  } list_result_t;

  // Shadow copy of the point list, kept in step with every accepted operation.
  logic signed [PointW-1:0] key_mem [CAPACITY];
  logic signed [PointW-1:0] val_mem [CAPACITY];
  int unsigned              fill_level;
  logic [IndexW-1:0]        mark_index;
  logic                     mark_on;

  list_result_t expected_q [$];

  function automatic list_result_t apply_list_op(input logic [KindW-1:0] kind,
                                                 input logic [IndexW-1:0] idx,
                                                 input logic signed [PointW-1:0] px,
                                                 input logic signed [PointW-1:0] py);
    list_result_t res;
    int unsigned  pos;
    int unsigned  j;
    res = '0;
    res.status = StatusDone;
    case (kind)
      KindInsert: begin
        if (fill_level >= CAPACITY) begin
          res.status = StatusFull;
        end else begin
          // The new point goes ahead of any stored point with an equal key.
          pos = 0;
          while (pos < fill_level && key_mem[pos] < px) pos++;
          for (j = fill_level; j > pos; j--) begin
            key_mem[j] = key_mem[j-1];
            val_mem[j] = val_mem[j-1];
          end
          key_mem[pos] = px;
          val_mem[pos] = py;
          fill_level++;
        end
      end
      KindRemove: begin
        if (idx >= fill_level) begin
          res.status = StatusRange;
        end else begin
          if (mark_on && mark_index == idx) mark_on = 1'b0;
          for (j = idx; j + 1 < fill_level; j++) begin
            key_mem[j] = key_mem[j+1];
            val_mem[j] = val_mem[j+1];
          end
          fill_level--;
        end
      end
      KindRead: begin
        if (idx >= fill_level) begin
          res.status = StatusRange;
        end else begin
          res.read_x = key_mem[idx];
          res.read_y = val_mem[idx];
        end
      end
      KindSetCur: begin
        if (idx >= fill_level) begin
          res.status = StatusRange;
        end else begin
          mark_index = idx;
          mark_on    = 1'b1;
        end
      end
      KindWriteCur: begin
        // The list is not re-sorted after an overwrite.
        if (!mark_on || mark_index >= fill_level) begin
          res.status = StatusRange;
        end else begin
          key_mem[mark_index] = px;
          val_mem[mark_index] = py;
        end
      end
      default: begin
      end
    endcase
    res.count = CountW'(fill_level);
    res.mark  = mark_on;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [PointW-1:0] want,
                             input logic [PointW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      fill_level       = 0;
      mark_index       = '0;
      mark_on          = 1'b0;
      mismatch_count_o = 0;
      expected_q.delete();
      pending_o        = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_list_op(kind_i, index_i, point_x_i, point_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual x %0h y %0h count %0d status %0d mark %b",
                   $time, read_x_i, read_y_i, entry_count_i, status_i, current_valid_i);
          mismatch_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("read_x", want.read_x, read_x_i);
          check_field("read_y", want.read_y, read_y_i);
          check_field("entry_count", PointW'(want.count), PointW'(entry_count_i));
          check_field("status", PointW'(want.status), PointW'(status_i));
          check_field("current_valid", PointW'(want.mark), PointW'(current_valid_i));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- bench/tb_sorted_point_list.sv -----
module tb_sorted_point_list;
  timeunit 1ns;
  timeprecision 1ps;

  import spl_pkg::*;

  // Run length and back-pressure figures.
  localparam int RandomItems = 1300;
  localparam int HoldCycles  = 300;
  localparam int BurstItems  = 40;
  localparam int SettleCycles = 10;
  localparam int CycleLimit  = 500000;

  // Corner keys of the signed Q16.16 range.
  localparam logic signed [PointW-1:0] KeyMax = 32'sh7FFF_FFFF;
  localparam logic signed [PointW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [PointW-1:0] KeyOne = 32'sh0001_0000;

  typedef enum int {PhaseGrow, PhaseShrink, PhaseMix} phase_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [KindW-1:0]          kind_i = KindInsert;
  logic [IndexW-1:0]         index_i = '0;
  logic signed [PointW-1:0]  point_x_i = '0;
  logic signed [PointW-1:0]  point_y_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [PointW-1:0]  read_x_o;
  logic signed [PointW-1:0]  read_y_o;
  logic [CountW-1:0]         entry_count_o;
  logic [StatusW-1:0]        status_o;
  logic                      current_valid_o;

  int mismatches;
  int pending_results;

  // Stimulus-side bookkeeping. The fill count depends only on the order of
  // operations, so the sender can track it exactly and aim its indexes.
  int unsigned list_fill = 0;
  bit          send_busy = 1'b1;
  bit          take_busy = 1'b1;
  bit          hold_req = 1'b0;
  int          burst_left = 0;
  int          cycle_count = 0;

  always #1 clk_i = ~clk_i;

  sorted_point_list i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .index_i        (index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_x_o       (read_x_o),
    .read_y_o       (read_y_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o),
    .current_valid_o(current_valid_o)
  );

  spl_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .kind_i          (kind_i),
    .index_i         (index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_x_i        (read_x_o),
    .read_y_i        (read_y_o),
    .entry_count_i   (entry_count_o),
    .status_i        (status_o),
    .current_valid_i (current_valid_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending_results)
  );

  // Offers one transaction and returns in the time step of the edge at which it
  // was taken. The caller then either drives the next transaction or lowers
  // valid in that same step, never both, so valid stays high across
  // back-to-back transactions. Handshake signals are sampled at the falling
  // edge, where they are settled and equal to what the next rising edge sees.
  task automatic send_op(input logic [KindW-1:0] kind, input logic [IndexW-1:0] idx,
                         input logic signed [PointW-1:0] px,
                         input logic signed [PointW-1:0] py);
    int   gap;
    logic ready_seen;
    gap = (send_busy && burst_left == 0) ? $urandom_range(0, 14) : 0;
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    index_i    <= idx;
    point_x_i  <= px;
    point_y_i  <= py;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    if (kind == KindInsert && list_fill < CAPACITY) list_fill++;
    else if (kind == KindRemove && idx < list_fill) list_fill--;
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Keys are drawn from the corners, from a narrow cluster of whole numbers
  // (so that equal keys are common and ties get exercised), or at random.
  function automatic logic signed [PointW-1:0] pick_key();
    int roll;
    int whole;
    roll  = $urandom_range(0, 99);
    whole = int'($urandom_range(0, 15)) - 8;
    if (roll < 8) begin
      case ($urandom_range(0, 3))
        0:       return KeyMax;
        1:       return KeyMin;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (roll < 40) return PointW'(whole) << 16;
    return $urandom;
  endfunction

  // Mostly a live entry, sometimes exactly one past the end, sometimes anywhere.
  function automatic logic [IndexW-1:0] pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (list_fill > 0 && roll < 75) return IndexW'($urandom_range(0, list_fill - 1));
    if (roll < 85 && list_fill < CAPACITY) return IndexW'(list_fill);
    return IndexW'($urandom_range(0, CAPACITY - 1));
  endfunction

  // One random transaction, with the mix of operations set by the phase: growth
  // phases run the list up to full and beyond, shrink phases empty it again.
  task automatic send_random(input phase_e phase);
    int               roll;
    int               w_ins;
    int               w_rem;
    int               w_rd;
    int               w_set;
    int               w_wr;
    logic [KindW-1:0] kind;
    case (phase)
      PhaseGrow: begin
        w_ins = 70; w_rem = 6;  w_rd = 8;  w_set = 6;  w_wr = 8;
      end
      PhaseShrink: begin
        w_ins = 10; w_rem = 60; w_rd = 12; w_set = 8;  w_wr = 8;
      end
      default: begin
        w_ins = 35; w_rem = 25; w_rd = 15; w_set = 10; w_wr = 13;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_ins) kind = KindInsert;
    else if (roll < w_ins + w_rem) kind = KindRemove;
    else if (roll < w_ins + w_rem + w_rd) kind = KindRead;
    else if (roll < w_ins + w_rem + w_rd + w_set) kind = KindSetCur;
    else if (roll < w_ins + w_rem + w_rd + w_set + w_wr) kind = KindWriteCur;
    else kind = KindWriteCur + KindW'($urandom_range(1, 3));
    send_op(kind, pick_index(), pick_key(), $urandom);
  endtask

  // Receiver: stalls for a random number of cycles before each result, with
  // stretches of no stalling, and on request holds off for a long stretch so
  // that the output register fills and the block stops taking transactions.
  initial begin
    int   gap;
    logic valid_seen;
    repeat (9) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 79) == 0) take_busy = !take_busy;
      gap = take_busy ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        valid_seen = out_valid_o;
        @(posedge clk_i);
      end while (!valid_seen);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    phase_e phase;
    int     phase_count;
    int     phase_len;
    int     random_sent;
    int     n;
    phase_count = 0;
    random_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every indexed operation is out of range, and write-current
    // is refused while the mark is off. Unused kinds report done.
    send_op(KindRead, '0, '0, '0);
    send_op(KindRemove, '0, '0, '0);
    send_op(KindSetCur, '0, '0, '0);
    send_op(KindWriteCur, '0, KeyOne, KeyOne);
    send_op(KindWriteCur + KindW'(1), '1, KeyMax, KeyMin);
    send_op(KindWriteCur + KindW'(3), '0, '1, '1);

    // Build a list holding both extremes and a tie: the second point with key
    // one lands ahead of the first.
    send_op(KindInsert, '0, KeyOne, KeyMax);
    send_op(KindInsert, '1, KeyMax, KeyMin);
    send_op(KindInsert, '0, KeyMin, '0);
    send_op(KindInsert, '0, KeyOne, 32'sh0000_1234);
    send_op(KindInsert, '0, '1, '1);
    send_op(KindRead, IndexW'(0), '0, '0);
    send_op(KindRead, IndexW'(4), '0, '0);
    send_op(KindRead, IndexW'(5), '0, '0);

    // Overwrite through the mark, then remove the marked entry, which clears
    // the mark, so the next overwrite is refused.
    send_op(KindSetCur, IndexW'(2), '0, '0);
    send_op(KindWriteCur, '0, KeyMax, KeyMin);
    send_op(KindRead, IndexW'(2), '0, '0);
    send_op(KindRemove, IndexW'(2), '0, '0);
    send_op(KindWriteCur, '0, KeyOne, KeyOne);

    // Removing below the mark leaves the mark index where it was.
    send_op(KindSetCur, IndexW'(3), '0, '0);
    send_op(KindRemove, IndexW'(0), '0, '0);
    send_op(KindWriteCur, '1, '0, '0);
    send_op(KindRead, IndexW'(3), '0, '0);
    send_op(KindRemove, '1, '0, '0);
    send_op(KindSetCur, '1, '0, '0);

    while (random_sent < RandomItems) begin
      phase     = (list_fill < 20) ? PhaseGrow : phase_e'($urandom_range(0, 2));
      send_busy = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(60, 160);
      // Once in the run: the receiver holds off while the sender keeps
      // offering transactions with no gaps.
      if (phase_count == 2) begin
        hold_req   = 1'b1;
        burst_left = BurstItems;
      end
      for (n = 0; n < phase_len; n++) send_random(phase);
      random_sent += phase_len;
      if (phase_count == 5 || $urandom_range(0, 4) == 0) wait_drained();
      phase_count++;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
